// ===== rtl/dapv_pkg.sv =====
// Package for the debug access packet validator: constants, opcodes and the
// front-to-back item type. No dependencies.
package dapv_pkg;

    localparam int PACKET_BYTES     = 64;
    localparam int JTAG_DEVICES     = 8;
    localparam int FW_VERSION_BYTES = 6;
    localparam int OFS_W            = $clog2(PACKET_BYTES + 2);
    localparam int RPL_W            = $clog2(PACKET_BYTES + 2) + 1;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] OP_INFO         = 8'h00;
    localparam logic [7:0] OP_HOST_STATUS  = 8'h01;
    localparam logic [7:0] OP_CONNECT      = 8'h02;
    localparam logic [7:0] OP_DISCONNECT   = 8'h03;
    localparam logic [7:0] OP_XFER_CONFIG  = 8'h04;
    localparam logic [7:0] OP_TRANSFER     = 8'h05;
    localparam logic [7:0] OP_XFER_BLOCK   = 8'h06;
    localparam logic [7:0] OP_WRITE_ABORT  = 8'h08;
    localparam logic [7:0] OP_DELAY        = 8'h09;
    localparam logic [7:0] OP_RESET_TARGET = 8'h0A;
    localparam logic [7:0] OP_SWJ_PINS     = 8'h10;
    localparam logic [7:0] OP_SWJ_CLOCK    = 8'h11;
    localparam logic [7:0] OP_SWJ_SEQ      = 8'h12;
    localparam logic [7:0] OP_SWD_CONFIG   = 8'h13;
    localparam logic [7:0] OP_JTAG_SEQ     = 8'h14;
    localparam logic [7:0] OP_JTAG_CONFIG  = 8'h15;
    localparam logic [7:0] OP_JTAG_IDCODE  = 8'h16;
    localparam logic [7:0] OP_SWD_SEQ      = 8'h1D;
    localparam logic [7:0] OP_QUEUE        = 8'h7E;
    localparam logic [7:0] OP_EXECUTE      = 8'h7F;

    localparam logic [7:0] F_RNW   = 8'h02;
    localparam logic [7:0] F_MATCH = 8'h10;
    localparam logic [7:0] F_STAMP = 8'h80;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       overflow;
    } dapv_item_t;

endpackage

// ===== rtl/dapv_front.sv =====
// Front part: accepts packet bytes, counts the packet offset and flags oversize.
// Depends on dapv_pkg.
module dapv_front
    import dapv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       in_fire,
    output dapv_item_t item
);

    logic [OFS_W-1:0] offset_reg;
    logic [OFS_W-1:0] offset_next;
    logic             over;

    always_comb
    begin
        over = (offset_reg >= OFS_W'(PACKET_BYTES));
        if (last_byte)
            offset_next = '0;
        else if (over)
            offset_next = offset_reg;
        else
            offset_next = offset_reg + OFS_W'(1);
        item.data     = data_byte;
        item.last     = last_byte;
        item.overflow = over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (in_fire)
            offset_reg <= offset_next;
    end

endmodule

// ===== rtl/dapv_queue.sv =====
// Short queue between front and back so each side stalls on its own.
// Depends on dapv_pkg.
module dapv_queue
    import dapv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  dapv_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output dapv_item_t pop_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    dapv_item_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]       wr_reg;
    logic [PW-1:0]       rd_reg;
    logic [PW:0]         cnt_reg;

    assign full      = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (pop)
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ===== rtl/dapv_back.sv =====
// Back part: walks command structure byte by byte, sums reply lengths and
// registers the result. Depends on dapv_pkg.
module dapv_back
    import dapv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  dapv_item_t item,
    output logic       item_take,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       res_ok,
    output logic [6:0] res_len
);

    typedef enum logic [3:0] {
        PH_FIRST, PH_BATCH_COUNT, PH_OPCODE, PH_ARG, PH_JCFG_IR, PH_SEQ_INFO,
        PH_XFER_IDX, PH_XFER_COUNT, PH_XFER_FLAGS, PH_XB_IDX, PH_XB_CLO,
        PH_XB_CHI, PH_XB_MODE, PH_SKIP, PH_PAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  op_reg, op_next;
    logic [17:0] skip_reg, skip_next;
    logic [15:0] items_reg, items_next;
    logic [8:0]  cmds_reg, cmds_next;
    logic [RPL_W-1:0] crep_reg, crep_next;
    logic [RPL_W-1:0] total_reg, total_next;
    logic        err_reg, err_next;
    logic        res_valid_reg, res_ok_reg;
    logic [6:0]  res_len_reg;

    logic [RPL_W+1:0] csum;
    logic [RPL_W:0]   tsum;
    logic [8:0]       n9;
    logic [3:0]       n4;
    logic [5:0]       bits6;
    logic [17:0]      xb_n;
    logic             fin, finish;
    logic [RPL_W+1:0] crep_w;
    logic             ok;

    assign item_take = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res_ok    = res_ok_reg;
    assign res_len   = res_len_reg;

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        skip_next  = skip_reg;
        items_next = items_reg;
        cmds_next  = cmds_reg;
        crep_w     = (RPL_W+2)'(crep_reg);
        total_next = total_reg;
        err_next   = err_reg || item.overflow;
        finish     = 1'b0;
        fin        = 1'b0;
        bits6      = item.data[5:0];
        n4         = 4'((((bits6 == 6'd0) ? 7'd64 : {1'b0, bits6}) + 7'd7) >> 3);
        n9         = 9'((((item.data == 8'd0) ? 10'd256 : {2'b0, item.data}) + 10'd7) >> 3);
        xb_n       = {items_reg, 2'b00};
        if (!err_next)
        begin
            unique case (phase_reg)
                PH_FIRST, PH_OPCODE:
                begin
                    if (phase_reg == PH_FIRST
                        && (item.data == OP_EXECUTE || item.data == OP_QUEUE))
                    begin
                        total_next = RPL_W'(2);
                        phase_next = PH_BATCH_COUNT;
                    end
                    else
                    begin
                        if (phase_reg == PH_FIRST)
                            cmds_next = 9'd1;
                        op_next    = item.data;
                        crep_w     = (RPL_W+2)'(2);
                        items_next = '0;
                        skip_next  = '0;
                        priority case (item.data)
                            OP_INFO, OP_SWJ_SEQ, OP_JTAG_CONFIG, OP_JTAG_SEQ, OP_SWD_SEQ:
                                phase_next = PH_ARG;
                            OP_HOST_STATUS, OP_DELAY: skip_next = 18'd2;
                            OP_CONNECT, OP_SWD_CONFIG: skip_next = 18'd1;
                            OP_DISCONNECT: fin = 1'b1;
                            OP_RESET_TARGET:
                            begin
                                crep_w = (RPL_W+2)'(3);
                                fin    = 1'b1;
                            end
                            OP_XFER_CONFIG, OP_WRITE_ABORT: skip_next = 18'd5;
                            OP_SWJ_PINS: skip_next = 18'd6;
                            OP_SWJ_CLOCK: skip_next = 18'd4;
                            OP_JTAG_IDCODE:
                            begin
                                crep_w    = (RPL_W+2)'(6);
                                skip_next = 18'd1;
                            end
                            OP_TRANSFER:
                            begin
                                crep_w     = (RPL_W+2)'(3);
                                phase_next = PH_XFER_IDX;
                            end
                            OP_XFER_BLOCK:
                            begin
                                crep_w     = (RPL_W+2)'(4);
                                phase_next = PH_XB_IDX;
                            end
                            OP_QUEUE, OP_EXECUTE: err_next = 1'b1;
                            default:
                            begin
                                crep_w = (RPL_W+2)'(1);
                                fin    = 1'b1;
                            end
                        endcase
                        if (skip_next != '0)
                            phase_next = PH_SKIP;
                    end
                end
                PH_BATCH_COUNT:
                begin
                    cmds_next  = {1'b0, item.data};
                    phase_next = (item.data != 8'd0) ? PH_OPCODE : PH_PAD;
                end
                PH_ARG:
                begin
                    priority case (op_reg)
                        OP_INFO:
                        begin
                            priority case (item.data)
                                8'h04: crep_w = (RPL_W+2)'(2 + FW_VERSION_BYTES);
                                8'hF0, 8'hFE: crep_w = (RPL_W+2)'(3);
                                8'hF1: crep_w = (RPL_W+2)'(6);
                                8'hFF: crep_w = (RPL_W+2)'(4);
                                default: crep_w = (RPL_W+2)'(2);
                            endcase
                            fin = 1'b1;
                        end
                        OP_SWJ_SEQ:
                        begin
                            skip_next  = 18'(n9);
                            phase_next = PH_SKIP;
                        end
                        OP_JTAG_CONFIG:
                        begin
                            if (item.data > 8'(JTAG_DEVICES))
                                err_next = 1'b1;
                            else
                            begin
                                items_next = {8'd0, item.data};
                                if (item.data != 8'd0) phase_next = PH_JCFG_IR;
                                else fin = 1'b1;
                            end
                        end
                        default:
                        begin
                            items_next = {8'd0, item.data};
                            if (item.data != 8'd0) phase_next = PH_SEQ_INFO;
                            else fin = 1'b1;
                        end
                    endcase
                end
                PH_JCFG_IR:
                begin
                    if (item.data == 8'd0 || item.data > 8'd32)
                        err_next = 1'b1;
                    else
                    begin
                        items_next = items_reg - 16'd1;
                        if (items_next == '0) fin = 1'b1;
                    end
                end
                PH_SEQ_INFO:
                begin
                    items_next = items_reg - 16'd1;
                    skip_next  = (op_reg == OP_JTAG_SEQ || !item.data[7]) ? 18'(n4) : '0;
                    if (item.data[7])
                        crep_w = crep_w + (RPL_W+2)'(n4);
                    if (crep_w > (RPL_W+2)'(PACKET_BYTES))
                        err_next = 1'b1;
                    else if (skip_next != '0) phase_next = PH_SKIP;
                    else if (items_next != '0) phase_next = PH_SEQ_INFO;
                    else fin = 1'b1;
                end
                PH_XFER_IDX: phase_next = PH_XFER_COUNT;
                PH_XFER_COUNT:
                begin
                    items_next = {8'd0, item.data};
                    if (item.data != 8'd0) phase_next = PH_XFER_FLAGS;
                    else fin = 1'b1;
                end
                PH_XFER_FLAGS:
                begin
                    items_next = items_reg - 16'd1;
                    skip_next  = (((item.data & F_RNW) == 8'd0)
                                  || ((item.data & F_MATCH) != 8'd0)) ? 18'd4 : '0;
                    if (((item.data & F_RNW) != 8'd0) && ((item.data & F_MATCH) == 8'd0))
                        crep_w = crep_w + (RPL_W+2)'(4);
                    if ((item.data & F_STAMP) != 8'd0)
                        crep_w = crep_w + (RPL_W+2)'(4);
                    if (crep_w > (RPL_W+2)'(PACKET_BYTES))
                        err_next = 1'b1;
                    else if (skip_next != '0) phase_next = PH_SKIP;
                    else if (items_next != '0) phase_next = PH_XFER_FLAGS;
                    else fin = 1'b1;
                end
                PH_XB_IDX: phase_next = PH_XB_CLO;
                PH_XB_CLO:
                begin
                    items_next = {8'd0, item.data};
                    phase_next = PH_XB_CHI;
                end
                PH_XB_CHI:
                begin
                    items_next = {item.data, items_reg[7:0]};
                    if (items_next != '0) phase_next = PH_XB_MODE;
                    else fin = 1'b1;
                end
                PH_XB_MODE:
                begin
                    items_next = '0;
                    if ((item.data & F_RNW) != 8'd0)
                    begin
                        // saturate the block reply; anything above the packet is an error
                        if (xb_n > 18'(PACKET_BYTES))
                            crep_w = (RPL_W+2)'(PACKET_BYTES + 1);
                        else
                            crep_w = (RPL_W+2)'(4) + (RPL_W+2)'(xb_n);
                        fin = 1'b1;
                    end
                    else
                    begin
                        skip_next  = xb_n;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 18'd1;
                    if (skip_next == '0)
                    begin
                        if (items_reg != '0)
                            phase_next = (op_reg == OP_TRANSFER) ? PH_XFER_FLAGS
                                                                 : PH_SEQ_INFO;
                        else
                            fin = 1'b1;
                    end
                end
                PH_PAD: ;
                default: ;
            endcase
        end
        finish = fin && !err_next;
        csum   = crep_w;
        if (finish && crep_w > (RPL_W+2)'(PACKET_BYTES))
        begin
            err_next = 1'b1;
            csum     = (RPL_W+2)'(PACKET_BYTES + 1);
        end
        tsum = (RPL_W+1)'(total_next) + (RPL_W+1)'(csum);
        if (finish)
        begin
            if (tsum > (RPL_W+1)'(PACKET_BYTES))
                err_next = 1'b1;
            else
                total_next = RPL_W'(tsum);
            cmds_next  = cmds_next - 9'd1;
            phase_next = (cmds_next != '0) ? PH_OPCODE : PH_PAD;
        end
        crep_next = RPL_W'(csum);
        ok        = !err_next && phase_next == PH_PAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            op_reg        <= '0;
            skip_reg      <= '0;
            items_reg     <= '0;
            cmds_reg      <= 9'd1;
            crep_reg      <= '0;
            total_reg     <= '0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_len_reg   <= '0;
        end
        else
        begin
            // a new result replaces the one taken in this same cycle
            if (item_take && item.last)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            if (item_take)
            begin
                if (item.last)
                begin
                    res_ok_reg    <= ok;
                    res_len_reg   <= ok ? 7'(total_next) : 7'd0;
                    phase_reg     <= PH_FIRST;
                    op_reg        <= '0;
                    skip_reg      <= '0;
                    items_reg     <= '0;
                    cmds_reg      <= 9'd1;
                    crep_reg      <= '0;
                    total_reg     <= '0;
                    err_reg       <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    op_reg    <= op_next;
                    skip_reg  <= skip_next;
                    items_reg <= items_next;
                    cmds_reg  <= cmds_next;
                    crep_reg  <= crep_next;
                    total_reg <= total_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

endmodule

// ===== rtl/debug_access_packet_validator_top.sv =====
// Debug access packet validator, top level. One request byte is taken per cycle
// while the queue has room (data_byte, last_byte on in_valid/in_ready); on the
// byte flagged last_byte one result (packet_ok, reply_length) leaves on
// out_valid/out_ready, and the next packet may start in the following cycle.
// Throughput is one byte a cycle, set by the parse step in the back part, unless
// a held result stalls the back. out_valid rises once the back has taken the
// last byte from the queue and registered the result. The front counts offsets
// and flags oversize packets, a two-entry queue decouples it from the back, which
// walks the command structure and holds the result until it is taken.
// Depends on dapv_pkg, dapv_front, dapv_queue and dapv_back.
module debug_access_packet_validator_top
    import dapv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       packet_ok,
    output logic [6:0] reply_length
);

    dapv_item_t front_item;
    dapv_item_t q_item;
    logic       q_full;
    logic       q_ne;
    logic       q_pop;
    logic       in_fire;

    // accept whenever the queue has room
    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    dapv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .in_fire   (in_fire),
        .item      (front_item)
    );

    dapv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_ne),
        .pop_item  (q_item)
    );

    // the back drains the queue unless its result register is blocked
    dapv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_ne),
        .item       (q_item),
        .item_take  (q_pop),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res_ok     (packet_ok),
        .res_len    (reply_length)
    );

`ifndef ASSERT_OFF
    // a failed packet reports zero reply length
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !packet_ok) |-> (reply_length == 7'd0))
        else $error("nonzero reply length on bad packet");
    // queue is never popped when empty
    a_pop_ne: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_ne)
        else $error("queue popped while empty");
    // a held result stays until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(packet_ok)
                                       && $stable(reply_length)))
        else $error("result changed while stalled");
`endif

endmodule

// ===== tb/dapv_checker.sv =====
// Checker for the debug access packet validator: watches both channels, predicts
// packet_ok and reply_length per packet and compares. Depends on dapv_pkg.
module dapv_checker
    import dapv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       packet_ok,
    input  logic [6:0] reply_length,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        PS_FIRST, PS_BATCH_COUNT, PS_OPCODE, PS_ARG, PS_JCFG_IR, PS_SEQ_INFO,
        PS_XFER_IDX, PS_XFER_COUNT, PS_XFER_FLAGS, PS_XB_IDX, PS_XB_CLO,
        PS_XB_CHI, PS_XB_MODE, PS_SKIP, PS_PAD
    } phase_e;

    typedef struct packed {
        logic       ok;
        logic [6:0] len;
    } verdict_t;

    verdict_t verdict_q[$];

    phase_e phase;
    int     offset, opcode, skip_left, items, cmds_left, cmd_reply, total_reply;
    bit     err;

    assign pending = verdict_q.size();

    function automatic void clear_packet();
        phase = PS_FIRST; offset = 0; opcode = 0; skip_left = 0; items = 0;
        cmds_left = 1; cmd_reply = 0; total_reply = 0; err = 0;
    endfunction

    function automatic void limit_cmd_reply();
        if (cmd_reply > PACKET_BYTES)
        begin
            err = 1;
            cmd_reply = PACKET_BYTES + 1;
        end
    endfunction

    function automatic void close_command();
        limit_cmd_reply();
        total_reply += cmd_reply;
        if (total_reply > PACKET_BYTES)
        begin
            err = 1;
            total_reply = PACKET_BYTES + 1;
        end
        cmds_left = (cmds_left - 1) & 'h1FF;
        phase = (cmds_left != 0) ? PS_OPCODE : PS_PAD;
    endfunction

    function automatic void advance_item(phase_e item_phase);
        if (skip_left != 0) phase = PS_SKIP;
        else if (items != 0) phase = item_phase;
        else close_command();
    endfunction

    function automatic void begin_skip(int n);
        skip_left = n;
        if (n != 0) phase = PS_SKIP;
        else close_command();
    endfunction

    function automatic void decode_opcode(logic [7:0] b);
        opcode = b;
        cmd_reply = 2;
        items = 0;
        case (b)
            OP_INFO, OP_SWJ_SEQ, OP_JTAG_CONFIG, OP_JTAG_SEQ, OP_SWD_SEQ: phase = PS_ARG;
            OP_HOST_STATUS, OP_DELAY:       begin_skip(2);
            OP_CONNECT, OP_SWD_CONFIG:      begin_skip(1);
            OP_DISCONNECT:                  close_command();
            OP_RESET_TARGET:
            begin
                cmd_reply = 3;
                close_command();
            end
            OP_XFER_CONFIG, OP_WRITE_ABORT: begin_skip(5);
            OP_SWJ_PINS:                    begin_skip(6);
            OP_SWJ_CLOCK:                   begin_skip(4);
            OP_JTAG_IDCODE:
            begin
                cmd_reply = 6;
                begin_skip(1);
            end
            OP_TRANSFER:
            begin
                cmd_reply = 3;
                phase = PS_XFER_IDX;
            end
            OP_XFER_BLOCK:
            begin
                cmd_reply = 4;
                phase = PS_XB_IDX;
            end
            OP_QUEUE, OP_EXECUTE:           err = 1;
            default:
            begin
                cmd_reply = 1;
                close_command();
            end
        endcase
    endfunction

    function automatic void decode_arg(logic [7:0] b);
        int n;
        if (opcode == OP_INFO)
        begin
            case (b)
                8'h04:        cmd_reply = 2 + FW_VERSION_BYTES;
                8'hF0, 8'hFE: cmd_reply = 3;
                8'hF1:        cmd_reply = 6;
                8'hFF:        cmd_reply = 4;
                default:      cmd_reply = 2;
            endcase
            close_command();
        end
        else if (opcode == OP_SWJ_SEQ)
        begin
            n = (b != 0) ? b : 256;
            begin_skip((n + 7) / 8);
        end
        else if (opcode == OP_JTAG_CONFIG)
        begin
            if (b > JTAG_DEVICES) err = 1;
            else
            begin
                items = b;
                if (b != 0) phase = PS_JCFG_IR;
                else close_command();
            end
        end
        else
        begin
            items = b;
            if (b != 0) phase = PS_SEQ_INFO;
            else close_command();
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int n;
        case (phase)
            PS_FIRST:
                if (b == OP_EXECUTE || b == OP_QUEUE)
                begin
                    total_reply = 2;
                    phase = PS_BATCH_COUNT;
                end
                else
                begin
                    cmds_left = 1;
                    decode_opcode(b);
                end
            PS_BATCH_COUNT:
            begin
                cmds_left = b;
                phase = (b != 0) ? PS_OPCODE : PS_PAD;
            end
            PS_OPCODE: decode_opcode(b);
            PS_ARG:    decode_arg(b);
            PS_JCFG_IR:
                if (b == 0 || b > 32) err = 1;
                else
                begin
                    items = (items - 1) & 'hFFFF;
                    if (items == 0) close_command();
                end
            PS_SEQ_INFO:
            begin
                n = (b[5:0] != 0) ? b[5:0] : 64;
                n = (n + 7) / 8;
                items = (items - 1) & 'hFFFF;
                skip_left = (opcode == OP_JTAG_SEQ || !b[7]) ? n : 0;
                if (b[7]) cmd_reply += n;
                limit_cmd_reply();
                if (!err) advance_item(PS_SEQ_INFO);
            end
            PS_XFER_IDX: phase = PS_XFER_COUNT;
            PS_XFER_COUNT:
            begin
                items = b;
                if (b != 0) phase = PS_XFER_FLAGS;
                else close_command();
            end
            PS_XFER_FLAGS:
            begin
                items = (items - 1) & 'hFFFF;
                skip_left = (((b & F_RNW) == 0) || ((b & F_MATCH) != 0)) ? 4 : 0;
                if ((b & F_RNW) != 0 && (b & F_MATCH) == 0) cmd_reply += 4;
                if ((b & F_STAMP) != 0) cmd_reply += 4;
                limit_cmd_reply();
                if (!err) advance_item(PS_XFER_FLAGS);
            end
            PS_XB_IDX: phase = PS_XB_CLO;
            PS_XB_CLO:
            begin
                items = b;
                phase = PS_XB_CHI;
            end
            PS_XB_CHI:
            begin
                items = items | (int'(b) << 8);
                if (items != 0) phase = PS_XB_MODE;
                else close_command();
            end
            PS_XB_MODE:
            begin
                n = 4 * items;
                items = 0;
                if ((b & F_RNW) != 0)
                begin
                    cmd_reply = 4 + n;
                    close_command();
                end
                else begin_skip(n);
            end
            PS_SKIP:
            begin
                skip_left = (skip_left - 1) & 'h3FFFF;
                if (skip_left == 0)
                    advance_item(opcode == OP_TRANSFER ? PS_XFER_FLAGS : PS_SEQ_INFO);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        clear_packet();
    end

    always @(posedge clk)
    begin
        verdict_t v;
        bit ok;
        if (rst_n)
        begin
            // result side first: the queue holds only items from earlier edges
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("unexpected result, packet_ok", packet_ok, -1);
                else
                begin
                    v = verdict_q.pop_front();
                    if (packet_ok !== v.ok) report_mismatch("packet_ok", packet_ok, v.ok);
                    if (reply_length !== v.len)
                        report_mismatch("reply_length", reply_length, v.len);
                end
            end
            if (in_valid && in_ready)
            begin
                if (offset < PACKET_BYTES) offset++;
                else
                begin
                    offset = PACKET_BYTES + 1;
                    err = 1;
                end
                if (!err) parse_byte(data_byte);
                if (last_byte)
                begin
                    ok = !err && phase == PS_PAD;
                    v.ok = ok;
                    v.len = ok ? total_reply[6:0] : 7'd0;
                    verdict_q.push_back(v);
                    clear_packet();
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
// Top of the debug access packet validator testbench: clock, reset, packet
// stimulus and verdict. Depends on dapv_pkg, dapv_checker and the RTL top.
module tb;
    import dapv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    logic [7:0] data_byte = 0;
    logic       last_byte = 0;
    logic       out_valid;
    logic       out_ready = 0;
    logic       packet_ok;
    logic [6:0] reply_length;
    int         fail_count;
    int         pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    longint cycle_count = 0;

    localparam longint CYCLE_LIMIT = 400000;

    byte unsigned pkt[$];

    always #2 clk = ~clk;

    debug_access_packet_validator_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .packet_ok(packet_ok), .reply_length(reply_length)
    );

    dapv_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .packet_ok(packet_ok), .reply_length(reply_length),
        .fail_count(fail_count), .pending(pending)
    );

    // Stall the result side at the phase's rate; redrawn every edge.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: abandon the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Push one byte and hold it until accepted; idle gaps come before it.
    task automatic push_byte(byte unsigned b, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid  <= 1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Valid is left high after the last byte; an idle gap in the next push or the drain drops it.
    task automatic send_packet();
        foreach (pkt[i])
            push_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
    endtask

    // Append one random command, mostly well formed with random content.
    task automatic add_command();
        int kind, n;
        byte unsigned ops[] = '{OP_INFO, OP_HOST_STATUS, OP_CONNECT, OP_DISCONNECT,
            OP_XFER_CONFIG, OP_WRITE_ABORT, OP_DELAY, OP_RESET_TARGET, OP_SWJ_PINS,
            OP_SWJ_CLOCK, OP_SWD_CONFIG, OP_JTAG_IDCODE};
        kind = $urandom_range(9);
        case (kind)
            0, 1:
            begin
                pkt.push_back(ops[$urandom_range(ops.size() - 1)]);
                repeat ($urandom_range(6)) pkt.push_back($urandom_range(255));
            end
            2:
            begin
                pkt.push_back(OP_TRANSFER);
                pkt.push_back($urandom_range(255));
                n = $urandom_range(4);
                pkt.push_back(n);
                repeat (n)
                begin
                    pkt.push_back($urandom_range(255));
                    if ($urandom_range(1)) repeat (4) pkt.push_back($urandom_range(255));
                end
            end
            3:
            begin
                pkt.push_back(OP_XFER_BLOCK);
                pkt.push_back($urandom_range(255));
                pkt.push_back($urandom_range(5));
                pkt.push_back($urandom_range(9) == 0 ? $urandom_range(255) : 0);
                pkt.push_back($urandom_range(255));
                repeat ($urandom_range(8)) pkt.push_back($urandom_range(255));
            end
            4:
            begin
                pkt.push_back($urandom_range(1) ? OP_JTAG_SEQ : OP_SWD_SEQ);
                n = $urandom_range(3);
                pkt.push_back(n);
                repeat (n)
                begin
                    pkt.push_back($urandom_range(255));
                    repeat ($urandom_range(3)) pkt.push_back($urandom_range(255));
                end
            end
            5:
            begin
                pkt.push_back(OP_JTAG_CONFIG);
                n = $urandom_range(9);
                pkt.push_back(n);
                repeat (n) pkt.push_back($urandom_range(5) == 0 ? $urandom_range(255)
                                                                : $urandom_range(1, 32));
            end
            6:
            begin
                pkt.push_back(OP_SWJ_SEQ);
                pkt.push_back($urandom_range(255));
                repeat ($urandom_range(8)) pkt.push_back($urandom_range(255));
            end
            7:
            begin
                pkt.push_back(OP_INFO);
                pkt.push_back($urandom_range(1) ? $urandom_range(255)
                                                : $urandom_range(240, 255));
            end
            default:
                pkt.push_back($urandom_range(255));
        endcase
    endtask

    task automatic random_packet();
        int n;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 70)) pkt.push_back($urandom_range(255));
        else
        begin
            if ($urandom_range(2) == 0)
            begin
                n = $urandom_range(1, 4);
                pkt.push_back($urandom_range(1) ? OP_EXECUTE : OP_QUEUE);
                pkt.push_back($urandom_range(7) == 0 ? $urandom_range(255) : n);
                repeat (n) add_command();
            end
            else
                add_command();
            // padding, sometimes up to and past the packet size
            if ($urandom_range(19) == 0)
                repeat ($urandom_range(40, 70)) pkt.push_back($urandom_range(255));
            else
                repeat ($urandom_range(3)) pkt.push_back($urandom_range(255));
        end
        if (pkt.size() == 0) pkt.push_back(OP_DISCONNECT);
        send_packet();
    endtask

    // Drop valid, let the checker log the last packet, then wait for all results.
    task automatic drain_results();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: plain commands, batches, nested batch, truncation, oversize,
        // JTAG configure limits, unknown opcode, info variants, errors.
        pkt = '{OP_DISCONNECT};                                       send_packet();
        pkt = '{OP_RESET_TARGET, 8'h00, 8'hFF};                       send_packet();
        pkt = '{OP_INFO, 8'h04};                                      send_packet();
        pkt = '{OP_INFO, 8'hFF};                                      send_packet();
        pkt = '{OP_EXECUTE, 8'd2, OP_INFO, 8'hF1, OP_JTAG_IDCODE, 8'h00};
        send_packet();
        pkt = '{OP_QUEUE, 8'd1, OP_EXECUTE, 8'd1, OP_DISCONNECT};     send_packet();
        pkt = '{OP_EXECUTE, 8'd3, OP_DISCONNECT};                     send_packet();
        pkt = '{OP_EXECUTE, 8'd0};                                    send_packet();
        pkt = '{OP_SWJ_PINS, 8'd1, 8'd2};                             send_packet();
        pkt = '{OP_JTAG_CONFIG, 8'd9, 8'd1};                          send_packet();
        pkt = '{OP_JTAG_CONFIG, 8'd2, 8'd32, 8'd0};                   send_packet();
        pkt = '{OP_JTAG_CONFIG, 8'd1, 8'd33};                         send_packet();
        pkt = '{8'hEE};                                               send_packet();
        pkt = '{OP_SWJ_SEQ, 8'd0};
        repeat (32) pkt.push_back(8'hA5);
        send_packet();
        pkt = '{OP_XFER_BLOCK, 8'd0, 8'd16, 8'd0, F_RNW};             send_packet();
        pkt = '{OP_XFER_BLOCK, 8'd0, 8'd15, 8'd0, F_RNW};             send_packet();
        pkt = '{OP_TRANSFER, 8'd0, 8'd1, 8'hFF};                      send_packet();
        pkt = '{OP_SWD_SEQ, 8'd1, 8'hC0};                             send_packet();
        pkt = '{OP_JTAG_SEQ, 8'd1, 8'h00};
        repeat (8) pkt.push_back(8'h5A);
        send_packet();
        pkt = '{OP_DISCONNECT};
        repeat (64) pkt.push_back(8'hFF);
        send_packet();

        // Hold off until every result is in before random traffic.
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            while (items_sent < (ph + 1) * 375)
                random_packet();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
